[design/lsrt_pkg.sv]
// Package for the LFU slot replacement table: sizes, result codes and the
// command and status structs between controller and datapath. No dependencies.
package lsrt_pkg;

  localparam int NUM_KEYS     = 128;
  localparam int MAX_FRAMES   = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int STAMP_WIDTH  = 32;
  localparam int ID_WIDTH     = 8;
  localparam int CFG_WIDTH    = 5;
  localparam int KIND_WIDTH   = 2;
  localparam int FRAME_RESET  = 16;
  localparam int IDX_WIDTH    = $clog2(NUM_KEYS);
  localparam int OCC_WIDTH    = $clog2(MAX_FRAMES + 1);
  localparam int ENTRY_WIDTH  = COUNT_WIDTH + STAMP_WIDTH;

  localparam logic REQ_VOTE = 1'b0;
  localparam logic REQ_LIST = 1'b1;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_VOTE   = 2'd0,
    KIND_LISTED = 2'd1,
    KIND_EMPTY  = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic accept;
    logic rd_cand;
    logic hit_write;
    logic insert;
    logic evict;
    logic occ_inc;
    logic scan_start;
    logic scan_step;
    logic list_step;
    logic list_finish;
    logic emit_vote;
    logic res_hit;
    logic res_ev;
  } lsrt_cmd_t;

  typedef struct packed {
    logic is_list;
    logic cand_valid;
    logic cand_resident;
    logic full;
    logic scan_done;
    logic best_found;
    logic list_done;
  } lsrt_status_t;

endpackage

[design/lsrt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/lsrt_ctrl.sv]
// Controller of the LFU slot replacement table: sequences votes, eviction
// scans and listings. Depends on lsrt_pkg.
module lsrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  lsrt_pkg::lsrt_status_t status_i,
  output lsrt_pkg::lsrt_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HIT_WAIT,
    ST_EVICT,
    ST_LIST
  } state_e;

  state_e state_q, state_d;
  logic   busy_q,  busy_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_list) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_LIST;
        end else if (!status_i.cand_valid) begin
          cmd_o.emit_vote = 1'b1;
          state_d         = ST_IDLE;
        end else if (status_i.cand_resident) begin
          cmd_o.rd_cand = 1'b1;
          state_d       = ST_HIT_WAIT;
        end else if (!status_i.full) begin
          cmd_o.insert    = 1'b1;
          cmd_o.occ_inc   = 1'b1;
          cmd_o.emit_vote = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_EVICT;
        end
      end
      ST_HIT_WAIT: begin
        cmd_o.hit_write = 1'b1;
        cmd_o.emit_vote = 1'b1;
        cmd_o.res_hit   = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_EVICT: begin
        if (status_i.scan_done) begin
          cmd_o.insert    = 1'b1;
          cmd_o.evict     = status_i.best_found;
          cmd_o.occ_inc   = !status_i.best_found;
          cmd_o.emit_vote = 1'b1;
          cmd_o.res_ev    = status_i.best_found;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_LIST: begin
        if (status_i.list_done) begin
          cmd_o.list_finish = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.list_step = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    busy_d = (state_d != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_idle_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !(cmd_o.insert || cmd_o.hit_write || cmd_o.scan_step || cmd_o.list_step))
    else $error("datapath command issued while idle");

endmodule

[design/lsrt_dp.sv]
// Datapath of the LFU slot replacement table: resident flags, count and
// stamp RAM, eviction search, list scan and result register.
// Depends on lsrt_pkg and lsrt_ram.
module lsrt_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lsrt_pkg::CFG_WIDTH-1:0]       cfg_data_i,
  input  logic                                 req_type_i,
  input  logic [lsrt_pkg::ID_WIDTH-1:0]        candidate_id_i,
  input  lsrt_pkg::lsrt_cmd_t                  cmd_i,
  output lsrt_pkg::lsrt_status_t               status_o,
  output logic                                 result_strobe_o,
  output logic [lsrt_pkg::KIND_WIDTH-1:0]      result_kind_o,
  output logic                                 was_hit_o,
  output logic                                 evicted_valid_o,
  output logic [lsrt_pkg::ID_WIDTH-1:0]        evicted_id_o,
  output logic [lsrt_pkg::ID_WIDTH-1:0]        listed_id_o,
  output logic                                 last_o
);

  localparam int IW = lsrt_pkg::IDX_WIDTH;
  localparam int DW = lsrt_pkg::ID_WIDTH;
  localparam int CW = lsrt_pkg::COUNT_WIDTH;
  localparam int SW = lsrt_pkg::STAMP_WIDTH;
  localparam int OW = lsrt_pkg::OCC_WIDTH;

  logic [lsrt_pkg::CFG_WIDTH-1:0] cfg_q;
  logic                           req_q;
  logic [DW-1:0]                  cand_q;
  logic [lsrt_pkg::NUM_KEYS-1:0]  resident_q;
  logic [lsrt_pkg::NUM_KEYS-1:0]  resident_d;
  logic [OW-1:0]                  occ_q;
  logic [SW-1:0]                  clock_q;

  logic [IW:0]    scan_idx_q;
  logic           pipe_v_q;
  logic           pipe_res_q;
  logic [IW-1:0]  pipe_idx_q;
  logic           best_found_q;
  logic [IW-1:0]  best_idx_q;
  logic [CW-1:0]  best_cnt_q;
  logic [SW-1:0]  best_stamp_q;
  logic [OW-1:0]  list_n_q;
  logic           pend_v_q;
  logic [DW-1:0]  pend_id_q;

  logic                                 strobe_q;
  logic [lsrt_pkg::KIND_WIDTH-1:0]      kind_q;
  logic                                 hit_q;
  logic                                 ev_q;
  logic [DW-1:0]                        ev_id_q;
  logic [DW-1:0]                        list_id_q;
  logic                                 last_q;

  logic [IW-1:0]                     cand_idx;
  logic [IW-1:0]                     scan_ptr;
  logic                              scan_end;
  logic [OW-1:0]                     cap;
  logic [lsrt_pkg::ENTRY_WIDTH-1:0]  rdata;
  logic [lsrt_pkg::ENTRY_WIDTH-1:0]  wdata;
  logic [CW-1:0]                     rd_cnt;
  logic [SW-1:0]                     rd_stamp;
  logic [CW-1:0]                     cnt_inc;
  logic                              better;
  logic                              ram_we;
  logic                              ram_re;
  logic [IW-1:0]                     ram_raddr;
  logic                              list_hit;
  logic [DW-1:0]                     scan_id;
  logic [DW-1:0]                     best_id;

  assign cand_idx = IW'(cand_q - DW'(1));
  assign scan_ptr = scan_idx_q[IW-1:0];
  assign scan_end = (scan_idx_q == (IW+1)'(lsrt_pkg::NUM_KEYS));
  assign scan_id  = DW'({1'b0, scan_ptr} + (IW+1)'(1));
  assign best_id  = DW'({1'b0, best_idx_q} + (IW+1)'(1));

  always_comb begin
    if (int'(cfg_q) > lsrt_pkg::MAX_FRAMES) begin
      cap = OW'(lsrt_pkg::MAX_FRAMES);
    end else if (cfg_q == '0) begin
      cap = OW'(1);
    end else begin
      cap = OW'(cfg_q);
    end
  end

  always_comb begin
    resident_d = resident_q;
    if (cmd_i.insert) begin
      resident_d[cand_idx] = 1'b1;
    end
    if (cmd_i.evict) begin
      resident_d[best_idx_q] = 1'b0;
    end
  end

  assign status_o.is_list       = (req_q == lsrt_pkg::REQ_LIST);
  assign status_o.cand_valid    = (cand_q != '0) && (int'(cand_q) <= lsrt_pkg::NUM_KEYS);
  assign status_o.cand_resident = resident_q[cand_idx];
  assign status_o.full          = (occ_q >= cap);
  assign status_o.scan_done     = scan_end && !pipe_v_q;
  assign status_o.best_found    = best_found_q;
  assign status_o.list_done     = scan_end || (int'(list_n_q) == lsrt_pkg::MAX_FRAMES);

  assign rd_cnt   = rdata[lsrt_pkg::ENTRY_WIDTH-1:SW];
  assign rd_stamp = rdata[SW-1:0];
  assign cnt_inc  = (rd_cnt == '1) ? rd_cnt : rd_cnt + CW'(1);
  assign better   = !best_found_q || (rd_cnt < best_cnt_q) ||
                    ((rd_cnt == best_cnt_q) && (rd_stamp < best_stamp_q));

  assign ram_we    = cmd_i.hit_write || cmd_i.insert;
  assign wdata     = cmd_i.hit_write ? {cnt_inc, rd_stamp} : {CW'(1), clock_q};
  assign ram_re    = cmd_i.rd_cand || (cmd_i.scan_step && !scan_end);
  assign ram_raddr = cmd_i.rd_cand ? cand_idx : scan_ptr;
  assign list_hit  = cmd_i.list_step && resident_q[scan_ptr];

  lsrt_ram #(
    .WIDTH (lsrt_pkg::ENTRY_WIDTH),
    .DEPTH (lsrt_pkg::NUM_KEYS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cand_idx),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= lsrt_pkg::CFG_WIDTH'(lsrt_pkg::FRAME_RESET);
      resident_q   <= '0;
      occ_q        <= '0;
      clock_q      <= '0;
      scan_idx_q   <= '0;
      pipe_v_q     <= 1'b0;
      best_found_q <= 1'b0;
      list_n_q     <= '0;
      pend_v_q     <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      resident_q <= resident_d;
      if (cmd_i.occ_inc) begin
        occ_q <= occ_q + OW'(1);
      end
      if (cmd_i.insert || cmd_i.hit_write) begin
        clock_q <= clock_q + SW'(1);
      end
      if (cmd_i.scan_start) begin
        scan_idx_q   <= '0;
        pipe_v_q     <= 1'b0;
        best_found_q <= 1'b0;
        list_n_q     <= '0;
        pend_v_q     <= 1'b0;
      end else begin
        pipe_v_q <= cmd_i.scan_step && !scan_end;
        if ((cmd_i.scan_step || cmd_i.list_step) && !scan_end) begin
          scan_idx_q <= scan_idx_q + (IW+1)'(1);
        end
        if (pipe_v_q && pipe_res_q && better) begin
          best_found_q <= 1'b1;
        end
        if (list_hit) begin
          list_n_q <= list_n_q + OW'(1);
          pend_v_q <= 1'b1;
        end
      end
      strobe_q <= cmd_i.emit_vote || cmd_i.list_finish || (list_hit && pend_v_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q  <= req_type_i;
      cand_q <= candidate_id_i;
    end
    pipe_res_q <= resident_q[scan_ptr];
    pipe_idx_q <= scan_ptr;
    if (pipe_v_q && pipe_res_q && better) begin
      best_idx_q   <= pipe_idx_q;
      best_cnt_q   <= rd_cnt;
      best_stamp_q <= rd_stamp;
    end
    if (list_hit) begin
      pend_id_q <= scan_id;
    end
    if (cmd_i.emit_vote) begin
      kind_q    <= lsrt_pkg::KIND_VOTE;
      hit_q     <= cmd_i.res_hit;
      ev_q      <= cmd_i.res_ev;
      ev_id_q   <= cmd_i.res_ev ? best_id : '0;
      list_id_q <= '0;
      last_q    <= 1'b1;
    end else if (cmd_i.list_finish) begin
      kind_q    <= pend_v_q ? lsrt_pkg::KIND_LISTED : lsrt_pkg::KIND_EMPTY;
      hit_q     <= 1'b0;
      ev_q      <= 1'b0;
      ev_id_q   <= '0;
      list_id_q <= pend_v_q ? pend_id_q : '0;
      last_q    <= 1'b1;
    end else if (list_hit && pend_v_q) begin
      kind_q    <= lsrt_pkg::KIND_LISTED;
      hit_q     <= 1'b0;
      ev_q      <= 1'b0;
      ev_id_q   <= '0;
      list_id_q <= pend_id_q;
      last_q    <= 1'b0;
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_kind_o   = kind_q;
  assign was_hit_o       = hit_q;
  assign evicted_valid_o = ev_q;
  assign evicted_id_o    = ev_id_q;
  assign listed_id_o     = list_id_q;
  assign last_o          = last_q;

  a_occ_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(resident_q) == int'(occ_q))
    else $error("resident flags disagree with occupancy");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(occ_q) <= lsrt_pkg::MAX_FRAMES)
    else $error("occupancy above frame limit");

  a_evict_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> (resident_q[best_idx_q] && (best_idx_q != cand_idx)))
    else $error("eviction of a key that is not resident");

  a_ev_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && ev_q) |-> (ev_id_q != '0))
    else $error("eviction reported without a key");

endmodule

[design/lfu_slot_replacement_table.sv]
// Top level of the LFU slot replacement table: controller and datapath.
// Depends on lsrt_pkg, lsrt_ctrl and lsrt_dp.
//
// One transaction is taken when start is high and busy is low; each result
// appears for exactly one cycle on result_strobe_o and cannot be held off.
// A vote for a resident key reads its entry in decode and writes the raised
// count in the wait state; a vote that inserts into a free slot writes in
// decode; a vote on a full table scans every key entry through the count and
// stamp RAM, one entry a cycle, and then inserts. A list walks the resident
// flags one key a cycle and finishes after the last key, earlier once
// MAX_FRAMES keys are found; listed keys follow the one before by the gap
// between resident keys. busy falls as the final result is shown, so the
// next transaction may start while that result is on the ports. Reset clears
// the resident flags at once, so no clearing pass is needed.
module lfu_slot_replacement_table (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lsrt_pkg::CFG_WIDTH-1:0]       cfg_data_i,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type_i,
  input  logic [lsrt_pkg::ID_WIDTH-1:0]        candidate_id_i,
  output logic                                 result_strobe_o,
  output logic [lsrt_pkg::KIND_WIDTH-1:0]      result_kind_o,
  output logic                                 was_hit_o,
  output logic                                 evicted_valid_o,
  output logic [lsrt_pkg::ID_WIDTH-1:0]        evicted_id_o,
  output logic [lsrt_pkg::ID_WIDTH-1:0]        listed_id_o,
  output logic                                 last_o
);

  lsrt_pkg::lsrt_cmd_t    cmd;
  lsrt_pkg::lsrt_status_t status;

  lsrt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lsrt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .candidate_id_i  (candidate_id_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_strobe_o (result_strobe_o),
    .result_kind_o   (result_kind_o),
    .was_hit_o       (was_hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_id_o    (evicted_id_o),
    .listed_id_o     (listed_id_o),
    .last_o          (last_o)
  );

endmodule
